### hdl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// shared types and constants of the power sequencer with watchdog timeouts
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int TimeW = 32;
    localparam int CfgIdxW = 2;

    localparam logic [TimeW-1:0] IdleTimeoutRst = TimeW'(120000);
    localparam logic [TimeW-1:0] StuckTimeoutRst = TimeW'(300000);
    localparam logic [TimeW-1:0] StartupTimeoutRst = TimeW'(120000);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IDLE_TIMEOUT = 2'd0,
        CFG_STUCK_TIMEOUT = 2'd1,
        CFG_STARTUP_TIMEOUT = 2'd2
    } psw_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_STARTING = 3'd0,
        ST_RUNNING = 3'd1,
        ST_STOPPING = 3'd2,
        ST_STOPPED = 3'd3,
        ST_SLEEPING = 3'd4,
        ST_ERROR = 3'd5
    } psw_state_t;

    typedef struct packed {
        logic [TimeW-1:0] idle_timeout_ms;
        logic [TimeW-1:0] stuck_timeout_ms;
        logic [TimeW-1:0] startup_timeout_ms;
    } psw_cfg_t;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic host_running;
        logic host_busy;
        logic motion_level;
        logic motion_rise;
        logic wake;
    } psw_item_t;

    typedef struct packed {
        psw_state_t fsm_state;
        logic [TimeW-1:0] entry_time;
        logic motion_flag;
        logic power_enable;
    } psw_ctx_t;

endpackage

### hdl/psw_cfg.sv
// ----------------------------------------------------------------------------
// psw_cfg
// timeout registers written through the plain configuration port
// ----------------------------------------------------------------------------
module psw_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [psw_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [psw_pkg::TimeW-1:0]     cfg_wdata,
    output psw_pkg::psw_cfg_t             cfg
);
    import psw_pkg::*;

    psw_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout_ms <= IdleTimeoutRst;
            cfg_reg.stuck_timeout_ms <= StuckTimeoutRst;
            cfg_reg.startup_timeout_ms <= StartupTimeoutRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDLE_TIMEOUT:    cfg_reg.idle_timeout_ms <= cfg_wdata;
                CFG_STUCK_TIMEOUT:   cfg_reg.stuck_timeout_ms <= cfg_wdata;
                CFG_STARTUP_TIMEOUT: cfg_reg.startup_timeout_ms <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/psw_step.sv
// ----------------------------------------------------------------------------
// psw_step
// one poll tick of the sequencer: timeout checks, motion override, state step
// ----------------------------------------------------------------------------
module psw_step (
    input  psw_pkg::psw_cfg_t   cfg,
    input  psw_pkg::psw_item_t  item,
    input  psw_pkg::psw_ctx_t   ctx,
    output psw_pkg::psw_ctx_t   ctx_next,
    output logic                cycle
);
    import psw_pkg::*;

    psw_state_t       s_idle;
    logic [TimeW-1:0] e_idle;
    psw_state_t       s_stuck;
    logic [TimeW-1:0] e_stuck;
    psw_state_t       s_mot;
    logic             mflag;
    logic             idle_hit;
    logic             stuck_hit;
    logic             startup_hit;

    always_comb
    begin
        ctx_next = ctx;
        cycle = 1'b0;
        mflag = (ctx.motion_flag | item.motion_rise) & item.motion_level;

        idle_hit = (ctx.fsm_state != ST_STOPPED)
            && ((item.now_ms - ctx.entry_time) > cfg.idle_timeout_ms) && !item.host_busy;
        s_idle = idle_hit ? ST_STOPPING : ctx.fsm_state;
        e_idle = idle_hit ? item.now_ms : ctx.entry_time;

        stuck_hit = (item.now_ms - e_idle) > cfg.stuck_timeout_ms;
        s_stuck = stuck_hit ? ST_ERROR : s_idle;
        e_stuck = stuck_hit ? item.now_ms : e_idle;

        s_mot = (mflag && s_stuck != ST_STARTING) ? ST_RUNNING : s_stuck;
        startup_hit = (item.now_ms - e_stuck) > cfg.startup_timeout_ms;

        if (!(ctx.fsm_state == ST_SLEEPING && !item.wake))
        begin
            ctx_next.motion_flag = mflag;
            ctx_next.fsm_state = s_mot;
            ctx_next.entry_time = e_stuck;
            unique case (s_mot)
                ST_STARTING:
                begin
                    if (item.host_running)
                    begin
                        ctx_next.fsm_state = ST_RUNNING;
                        ctx_next.entry_time = item.now_ms;
                    end
                    else if (startup_hit)
                    begin
                        ctx_next.fsm_state = ST_ERROR;
                        ctx_next.entry_time = item.now_ms;
                    end
                end
                ST_RUNNING:
                begin
                    if (!item.host_running)
                    begin
                        ctx_next.fsm_state = ST_STOPPING;
                        ctx_next.entry_time = item.now_ms;
                    end
                end
                ST_STOPPING:
                begin
                    ctx_next.fsm_state = ST_STOPPED;
                    ctx_next.entry_time = item.now_ms;
                end
                ST_STOPPED:
                begin
                    ctx_next.fsm_state = ST_SLEEPING;
                    ctx_next.entry_time = item.now_ms;
                    ctx_next.power_enable = 1'b0;
                end
                ST_SLEEPING:
                begin
                    ctx_next.fsm_state = ST_STARTING;
                    ctx_next.entry_time = item.now_ms;
                    ctx_next.power_enable = 1'b1;
                end
                ST_ERROR:
                begin
                    cycle = !item.host_running;
                    ctx_next.power_enable = 1'b1;
                    ctx_next.entry_time = item.now_ms;
                    ctx_next.fsm_state = ST_STARTING;
                end
                default:
                begin
                    // undefined state code: treat as a dead host
                    cycle = 1'b1;
                    ctx_next.power_enable = 1'b1;
                    ctx_next.fsm_state = ST_STARTING;
                end
            endcase
        end
    end

endmodule

### hdl/power_sequencer_watchdog_fsm.sv
// ----------------------------------------------------------------------------
// power_sequencer_watchdog_fsm
// six-state host power sequencer with idle, stuck and startup watchdogs
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one poll tick per item: the
//   millisecond time and the host, motion and wake flags. The output channel
//   (out_valid / out_stall) returns exactly one result per tick: the state
//   after the tick, the power enable level, a power cycle pulse and the
//   sleep request.
//   The tick is evaluated straight from the input register, and the state
//   and result registers load together from it once the output side
//   advances. Throughput is one item per cycle while out_stall is low; the
//   state update of one tick is ready for the next item in the following
//   cycle.
//   When out_stall holds, the result register keeps its item and the input
//   register can still take one more item before in_stall rises.
//   Reset leaves the sequencer in starting with power on, the motion flag
//   clear, entry time zero and the timeouts at their defaults. The user writes
//   timeouts via cfg_we/cfg_index/cfg_wdata while idle; block does not enforce.
// ----------------------------------------------------------------------------
module power_sequencer_watchdog_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [psw_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [psw_pkg::TimeW-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [psw_pkg::TimeW-1:0]     now_ms,
    input  logic                          host_running,
    input  logic                          host_busy,
    input  logic                          motion_level,
    input  logic                          motion_rise,
    input  logic                          wake,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    fsm_state_out,
    output logic                          power_on,
    output logic                          power_cycle,
    output logic                          sleep_request
);
    import psw_pkg::*;

    psw_cfg_t  cfg;
    psw_item_t item_reg;
    logic      in_valid_reg;
    psw_ctx_t  ctx_reg;
    psw_ctx_t  ctx_next;
    logic      cycle_next;
    logic      out_valid_reg;
    logic [2:0] state_out_reg;
    logic      power_on_reg;
    logic      power_cycle_reg;
    logic      sleep_request_reg;
    logic      advance;

    psw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    psw_step u_step (
        .cfg      (cfg),
        .item     (item_reg),
        .ctx      (ctx_reg),
        .ctx_next (ctx_next),
        .cycle    (cycle_next)
    );

    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.now_ms <= now_ms;
            item_reg.host_running <= host_running;
            item_reg.host_busy <= host_busy;
            item_reg.motion_level <= motion_level;
            item_reg.motion_rise <= motion_rise;
            item_reg.wake <= wake;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.fsm_state <= ST_STARTING;
            ctx_reg.entry_time <= '0;
            ctx_reg.motion_flag <= 1'b0;
            ctx_reg.power_enable <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                ctx_reg <= ctx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            state_out_reg <= ctx_next.fsm_state;
            power_on_reg <= ctx_next.power_enable;
            power_cycle_reg <= cycle_next;
            sleep_request_reg <= (ctx_next.fsm_state == ST_SLEEPING);
        end
    end

    assign out_valid = out_valid_reg;
    assign fsm_state_out = state_out_reg;
    assign power_on = power_on_reg;
    assign power_cycle = power_cycle_reg;
    assign sleep_request = sleep_request_reg;

endmodule

### hdl/psw_checker.sv
// ----------------------------------------------------------------------------
// psw_checker
// port-level checks of the power sequencer, bound to the top level
// ----------------------------------------------------------------------------
module psw_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [2:0]                    fsm_state_out,
    input  logic                          power_on,
    input  logic                          power_cycle,
    input  logic                          sleep_request
);
    import psw_pkg::*;

    // sleep request mirrors the sleeping state
    a_sleep_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sleep_request == (fsm_state_out == ST_SLEEPING)))
    else $error("sleep_request does not match state");

    // a power cycle always restarts with power on
    a_cycle_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && power_cycle) |-> (power_on && fsm_state_out == ST_STARTING))
    else $error("power cycle without restart");

    // sleeping never keeps power on
    a_sleep_power: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fsm_state_out == ST_SLEEPING) |-> !power_on)
    else $error("power on while sleeping");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

    // input side stalls only when the output side is stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");

endmodule

bind power_sequencer_watchdog_fsm psw_checker u_psw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fsm_state_out (fsm_state_out),
    .power_on      (power_on),
    .power_cycle   (power_cycle),
    .sleep_request (sleep_request)
);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the host power sequencer with watchdog timeouts
// ----------------------------------------------------------------------------
// Each poll tick sent to the sequencer is also run through a behavioral model
// kept in this bench, and the modeled result is queued. Every result taken
// from the block is checked field by field against the oldest queued one.
// Directed tests walk the power sequence, the startup, stuck and idle
// watchdogs, the motion override and the timeout register extremes. Random
// phases follow, with new timeout settings and random gaps on both sides, a
// long output hold-off, and a final stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb;

    import psw_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [2:0] state;
        logic power;
        logic cycle;
        logic sleep;
    } seq_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [TimeW-1:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic [TimeW-1:0] now_ms;
    logic host_running;
    logic host_busy;
    logic motion_level;
    logic motion_rise;
    logic wake;
    logic out_valid;
    logic out_stall;
    logic [2:0] fsm_state_out;
    logic power_on;
    logic power_cycle;
    logic sleep_request;

    // sequencer model state and timeout copies
    logic [2:0] seq_state;
    logic [TimeW-1:0] seq_entry;
    logic seq_motion;
    logic seq_power;
    logic [TimeW-1:0] idle_to;
    logic [TimeW-1:0] stuck_to;
    logic [TimeW-1:0] startup_to;

    seq_result_t pending_results[$];
    int unsigned mismatch_count;
    logic [TimeW-1:0] now_cursor;
    logic gaps_on;
    logic stalls_on;
    logic hold_req;

    power_sequencer_watchdog_fsm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .now_ms        (now_ms),
        .host_running  (host_running),
        .host_busy     (host_busy),
        .motion_level  (motion_level),
        .motion_rise   (motion_rise),
        .wake          (wake),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fsm_state_out (fsm_state_out),
        .power_on      (power_on),
        .power_cycle   (power_cycle),
        .sleep_request (sleep_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic seq_result_t sequencer_step(input psw_item_t t);
        seq_result_t r;
        logic pulse;
        pulse = 1'b0;
        if (!(seq_state == ST_SLEEPING && !t.wake))
        begin
            if (t.motion_rise)
                seq_motion = 1'b1;
            if (seq_motion && !t.motion_level)
                seq_motion = 1'b0;
            if (seq_state != ST_STOPPED && (t.now_ms - seq_entry) > idle_to && !t.host_busy)
            begin
                seq_state = ST_STOPPING;
                seq_entry = t.now_ms;
            end
            if ((t.now_ms - seq_entry) > stuck_to)
            begin
                seq_state = ST_ERROR;
                seq_entry = t.now_ms;
            end
            if (seq_motion && seq_state != ST_STARTING)
                seq_state = ST_RUNNING;
            case (seq_state)
                ST_STARTING:
                begin
                    if (t.host_running)
                    begin
                        seq_state = ST_RUNNING;
                        seq_entry = t.now_ms;
                    end
                    else if ((t.now_ms - seq_entry) > startup_to)
                    begin
                        seq_state = ST_ERROR;
                        seq_entry = t.now_ms;
                    end
                end
                ST_RUNNING:
                begin
                    if (!t.host_running)
                    begin
                        seq_state = ST_STOPPING;
                        seq_entry = t.now_ms;
                    end
                end
                ST_STOPPING:
                begin
                    seq_state = ST_STOPPED;
                    seq_entry = t.now_ms;
                end
                ST_STOPPED:
                begin
                    seq_state = ST_SLEEPING;
                    seq_entry = t.now_ms;
                    seq_power = 1'b0;
                end
                ST_SLEEPING:
                begin
                    seq_state = ST_STARTING;
                    seq_entry = t.now_ms;
                    seq_power = 1'b1;
                end
                ST_ERROR:
                begin
                    pulse = !t.host_running;
                    seq_power = 1'b1;
                    seq_entry = t.now_ms;
                    seq_state = ST_STARTING;
                end
                default:
                begin
                    pulse = 1'b1;
                    seq_power = 1'b1;
                    seq_state = ST_STARTING;
                end
            endcase
        end
        r.state = seq_state;
        r.power = seq_power;
        r.cycle = pulse;
        r.sleep = (seq_state == ST_SLEEPING);
        return r;
    endfunction

    function automatic psw_item_t make_tick(input logic [TimeW-1:0] t_ms, input logic run,
                                            input logic busy, input logic lvl,
                                            input logic rise, input logic wk);
        psw_item_t t;
        t.now_ms = t_ms;
        t.host_running = run;
        t.host_busy = busy;
        t.motion_level = lvl;
        t.motion_rise = rise;
        t.wake = wk;
        return t;
    endfunction

    function automatic psw_item_t random_tick();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 10)
            now_cursor = now_cursor + $urandom_range(0, 2000);
        else if (sel < 16)
            now_cursor = now_cursor + $urandom_range(0, 200000);
        else if (sel < 19)
            now_cursor = now_cursor + $urandom_range(0, 400000);
        else
            now_cursor = $urandom();
        return make_tick(now_cursor, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0,
                         $urandom_range(0, 2) == 0);
    endfunction

    function automatic logic [TimeW-1:0] random_timeout();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return $urandom_range(1, 5000);
            3: return $urandom_range(100000, 400000);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_tick(input psw_item_t t);
        int unsigned gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        now_ms <= t.now_ms;
        host_running <= t.host_running;
        host_busy <= t.host_busy;
        motion_level <= t.motion_level;
        motion_rise <= t.motion_rise;
        wake <= t.wake;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(sequencer_step(t));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IDLE_TIMEOUT: idle_to = val;
            CFG_STUCK_TIMEOUT: stuck_to = val;
            CFG_STARTUP_TIMEOUT: startup_to = val;
            default: ;
        endcase
    endtask

    task automatic write_all_timeouts(input logic [TimeW-1:0] idle_v,
                                      input logic [TimeW-1:0] stuck_v,
                                      input logic [TimeW-1:0] startup_v);
        write_timeout(CFG_IDLE_TIMEOUT, idle_v);
        write_timeout(CFG_STUCK_TIMEOUT, stuck_v);
        write_timeout(CFG_STARTUP_TIMEOUT, startup_v);
    endtask

    // start, run, stop, sleep, stay asleep, wake
    task automatic test_power_sequence();
        send_tick(make_tick(0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(2000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(2100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(2200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(2300, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(2400, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        now_cursor = 2400;
    endtask

    // startup timeout to error with dead host, then stuck timeout with live host
    task automatic test_startup_and_stuck();
        now_cursor = now_cursor + 120001;
        send_tick(make_tick(now_cursor, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        now_cursor = now_cursor + 10;
        send_tick(make_tick(now_cursor, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        now_cursor = now_cursor + 10;
        send_tick(make_tick(now_cursor, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        now_cursor = now_cursor + 300001;
        send_tick(make_tick(now_cursor, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_motion_override();
        now_cursor = now_cursor + 10;
        send_tick(make_tick(now_cursor, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        now_cursor = now_cursor + 10;
        send_tick(make_tick(now_cursor, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        now_cursor = now_cursor + 10;
        send_tick(make_tick(now_cursor, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        now_cursor = now_cursor + 10;
        send_tick(make_tick(now_cursor, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    endtask

    // idle timeout, then time wrapping through all ones to zero
    task automatic test_idle_and_wrap();
        now_cursor = now_cursor + 120001;
        send_tick(make_tick(now_cursor, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick('1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        now_cursor = '0;
    endtask

    task automatic test_timeout_extremes();
        int i;
        wait_results_drained();
        write_all_timeouts('0, '0, '0);
        for (i = 0; i < 3; i++)
        begin
            now_cursor = now_cursor + i;
            send_tick(make_tick(now_cursor, i[0], i[1], 1'b1, i[0], 1'b1));
        end
        wait_results_drained();
        write_all_timeouts('1, '1, '1);
        write_timeout(CFG_UNMAPPED, '0);
        for (i = 0; i < 3; i++)
            send_tick(random_tick());
    endtask

    task automatic test_random_phases();
        int p;
        int i;
        for (p = 0; p < 9; p++)
        begin
            wait_results_drained();
            case (p)
                0: write_all_timeouts(IdleTimeoutRst, StuckTimeoutRst, StartupTimeoutRst);
                1: write_all_timeouts('0, '0, '0);
                2: write_all_timeouts('1, '1, '1);
                3: write_all_timeouts($urandom_range(100, 3000), $urandom_range(100, 5000),
                                      $urandom_range(100, 3000));
                default: write_all_timeouts(random_timeout(), random_timeout(), random_timeout());
            endcase
            if (p == 4)
            begin
                write_timeout(CFG_UNMAPPED, $urandom());
                now_cursor = 32'hFFF0_0000;
            end
            for (i = 0; i < 110; i++)
                send_tick(random_tick());
        end
    endtask

    task automatic test_output_holdoff();
        int i;
        wait_results_drained();
        write_all_timeouts($urandom_range(100, 5000), $urandom_range(1000, 20000),
                           $urandom_range(100, 5000));
        gaps_on = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_tick(random_tick());
        gaps_on = 1'b1;
        wait_results_drained();
    endtask

    task automatic test_steady_stream();
        int i;
        write_all_timeouts(IdleTimeoutRst, StuckTimeoutRst, StartupTimeoutRst);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        for (i = 0; i < 100; i++)
            send_tick(random_tick());
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        seq_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no tick pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (fsm_state_out !== want.state)
                begin
                    $error("fsm_state_out: expected %0d, actual %0d", want.state, fsm_state_out);
                    mismatch_count++;
                end
                if (power_on !== want.power)
                begin
                    $error("power_on: expected %0b, actual %0b", want.power, power_on);
                    mismatch_count++;
                end
                if (power_cycle !== want.cycle)
                begin
                    $error("power_cycle: expected %0b, actual %0b", want.cycle, power_cycle);
                    mismatch_count++;
                end
                if (sleep_request !== want.sleep)
                begin
                    $error("sleep_request: expected %0b, actual %0b", want.sleep, sleep_request);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_IDLE_TIMEOUT;
        cfg_wdata = '0;
        in_valid = 1'b0;
        now_ms = '0;
        host_running = 1'b0;
        host_busy = 1'b0;
        motion_level = 1'b0;
        motion_rise = 1'b0;
        wake = 1'b0;
        seq_state = ST_STARTING;
        seq_entry = '0;
        seq_motion = 1'b0;
        seq_power = 1'b1;
        idle_to = IdleTimeoutRst;
        stuck_to = StuckTimeoutRst;
        startup_to = StartupTimeoutRst;
        mismatch_count = 0;
        now_cursor = '0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        hold_req = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_sequence();
        test_startup_and_stuck();
        test_motion_override();
        test_idle_and_wrap();
        test_timeout_extremes();
        test_random_phases();
        test_output_holdoff();
        test_steady_stream();

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
hdl/psw_pkg.sv
hdl/psw_cfg.sv
hdl/psw_step.sv
hdl/power_sequencer_watchdog_fsm.sv
hdl/psw_checker.sv
verif/tb.sv
